/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by multi_queue_fifo_top
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/mqf_pkg.sv */
// ----------------------------------------------------------------------------
// mqf_pkg
// shared constants and types of the multi queue fifo
// ----------------------------------------------------------------------------
package mqf_pkg;

    localparam int NUM_QUEUES_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF  = 64;
    localparam int HANDLE_WIDTH_DEF = 32;

    localparam int ITEM_W = 32;
    localparam int QID_W  = 3;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // decision taken in the lookup cycle
    typedef struct packed {
        logic do_write;
        logic do_read;
        logic dropped;
    } mqf_op_t;

endpackage

/* rtl/multi_queue_fifo_top.sv */
// ----------------------------------------------------------------------------
// multi_queue_fifo_top
// several handle queues sharing one item memory
// ----------------------------------------------------------------------------
// usage
//   a request (req_type, queue_id, item_in) is taken when start is high and
//   busy is low. req_type push appends item_in to the queue, pop removes
//   the head. each request yields exactly one result, shown for a single
//   cycle with done high: item_out and item_valid for a pop that found a
//   handle, push_dropped for a push to a full or nonexistent queue.
//   results cannot be held off; the receiver must take them when done is set.
// timing
//   accept edge reads the pointer memory, the next cycle updates pointers
//   and reads or writes the item memory, the cycle after shows the result.
//   done is high in the result state that follows the lookup, and busy stays
//   high from the accept edge until that result is shown, so a new request
//   is taken only once the last one is through. the pacing is set by the
//   pointer memory read-modify-write followed by the item memory read.
// reset
//   rst_n clears the control state and the per-queue initialized bits, so
//   every queue reads as empty at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_queue_fifo_top #(
    parameter int NUM_QUEUES   = mqf_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH  = mqf_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_WIDTH = mqf_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       req_type,
    input  logic [mqf_pkg::QID_W-1:0]  queue_id,
    input  logic [mqf_pkg::ITEM_W-1:0] item_in,
    output logic                       done,
    output logic [mqf_pkg::ITEM_W-1:0] item_out,
    output logic                       item_valid,
    output logic                       push_dropped
);
    import mqf_pkg::*;

    // queue index and item memory geometry
    localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int AW  = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    // stored handle width, bits above the port width would always be zero
    localparam int SW  = (HANDLE_WIDTH < ITEM_W) ? HANDLE_WIDTH : ITEM_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_RESULT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic          accept;
    logic [8:0]    qid_wide;
    logic          in_range;
    logic [QIW-1:0] qidx;

    mqf_op_t       op;
    logic [AW-1:0] slot_addr;

    // shared handle store
    logic [SW-1:0] item_mem [NUM_QUEUES * QUEUE_DEPTH];
    logic [SW-1:0] handle_reg;
    logic [SW-1:0] rd_data_reg;
    logic          res_valid_reg;
    logic          res_drop_reg;

    // request acceptance and queue decode
    assign accept   = start && !busy;
    assign qid_wide = 9'(queue_id);
    assign in_range = (qid_wide < 9'(NUM_QUEUES));
    assign qidx     = qid_wide[QIW-1:0];

    mqf_ptr_table #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .QIW         (QIW),
        .AW          (AW)
    ) u_ptr (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (accept),
        .rd_qidx     (qidx),
        .rd_pop      (req_type),
        .rd_in_range (in_range),
        .op          (op),
        .slot_addr   (slot_addr)
    );

    // sequencer: accept, lookup and memory access, result strobe
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: state_next = S_RESULT;
            S_RESULT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            res_drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LOOKUP)
            begin
                res_valid_reg <= op.do_read;
                res_drop_reg  <= op.dropped;
            end
        end
    end

    // handle capture and item memory port; pointer update in the lookup
    // cycle guarantees no overlap on the same entry between requests
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            handle_reg <= item_in[SW-1:0];
        end
        if (op.do_write)
        begin
            item_mem[slot_addr] <= handle_reg;
        end
        if (op.do_read)
        begin
            rd_data_reg <= item_mem[slot_addr];
        end
    end

    // result ports, zero outside the strobe cycle
    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_RESULT);
    assign item_valid   = done && res_valid_reg;
    assign push_dropped = done && res_drop_reg;
    assign item_out     = item_valid ? ITEM_W'(rd_data_reg) : '0;

    // checks
    `ASSERT_IMPLIES(a_result_two_after_accept, clk, rst_n, accept, ##2 done)
    `ASSERT_IMPLIES(a_pop_push_exclusive, clk, rst_n, done, !(item_valid && push_dropped))
    `ASSERT_NEXT(a_one_memory_op, clk, rst_n, state_reg == S_IDLE, !(op.do_write && op.do_read))

endmodule

/* rtl/mqf_ptr_table.sv */
// ----------------------------------------------------------------------------
// mqf_ptr_table
// per-queue head and count memory with read-modify-write
// ----------------------------------------------------------------------------
module mqf_ptr_table #(
    parameter int NUM_QUEUES  = mqf_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqf_pkg::QUEUE_DEPTH_DEF,
    parameter int QIW         = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
    parameter int AW          = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [QIW-1:0]  rd_qidx,
    input  logic            rd_pop,
    input  logic            rd_in_range,
    output mqf_pkg::mqf_op_t op,
    output logic [AW-1:0]   slot_addr
);
    import mqf_pkg::*;

    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [HW+CW-1:0]     ptr_mem [NUM_QUEUES];
    logic [HW+CW-1:0]     ptr_rd_reg;
    logic [NUM_QUEUES-1:0] init_reg;
    logic                 init_rd_reg;
    logic                 stage_reg;
    logic [QIW-1:0]       qidx_reg;
    logic                 pop_reg;
    logic                 range_reg;

    logic [HW-1:0] cur_head;
    logic [CW-1:0] cur_cnt;
    logic          full;
    logic          empty;
    logic [HW:0]   tail_sum;
    logic [HW:0]   tail_wrap;
    logic [HW:0]   head_inc;
    logic [HW-1:0] head_new;
    logic [CW-1:0] cnt_new;
    logic [HW-1:0] slot_pos;
    logic          wr_en;

    // memory read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ptr_rd_reg <= ptr_mem[rd_qidx];
        end
        if (wr_en)
        begin
            ptr_mem[qidx_reg] <= {head_new, cnt_new};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg    <= '0;
            init_rd_reg <= 1'b0;
            stage_reg   <= 1'b0;
            qidx_reg    <= '0;
            pop_reg     <= 1'b0;
            range_reg   <= 1'b0;
        end
        else
        begin
            stage_reg <= rd_en;
            if (rd_en)
            begin
                init_rd_reg <= init_reg[rd_qidx];
                qidx_reg    <= rd_qidx;
                pop_reg     <= rd_pop;
                range_reg   <= rd_in_range;
            end
            if (wr_en)
            begin
                init_reg[qidx_reg] <= 1'b1;
            end
        end
    end

    // an entry never written reads as empty queue, head zero
    assign cur_head = init_rd_reg ? ptr_rd_reg[HW+CW-1:CW] : '0;
    assign cur_cnt  = init_rd_reg ? ptr_rd_reg[CW-1:0] : '0;

    assign full  = (cur_cnt == CW'(QUEUE_DEPTH));
    assign empty = (cur_cnt == '0);

    // tail slot, wrapped within the queue
    assign tail_sum  = {1'b0, cur_head} + (HW+1)'(cur_cnt);
    assign tail_wrap = (tail_sum >= (HW+1)'(QUEUE_DEPTH)) ?
                       (tail_sum - (HW+1)'(QUEUE_DEPTH)) : tail_sum;
    assign head_inc  = {1'b0, cur_head} + (HW+1)'(1);

    always_comb
    begin
        op       = '0;
        head_new = cur_head;
        cnt_new  = cur_cnt;
        slot_pos = cur_head;
        if (stage_reg)
        begin
            if (!range_reg)
            begin
                op.dropped = (pop_reg == REQ_PUSH);
            end
            else if (pop_reg == REQ_PUSH)
            begin
                slot_pos = tail_wrap[HW-1:0];
                if (full)
                begin
                    op.dropped = 1'b1;
                end
                else
                begin
                    op.do_write = 1'b1;
                    cnt_new     = cur_cnt + CW'(1);
                end
            end
            else if (!empty)
            begin
                op.do_read = 1'b1;
                cnt_new    = cur_cnt - CW'(1);
                head_new   = (head_inc == (HW+1)'(QUEUE_DEPTH)) ? '0 : head_inc[HW-1:0];
            end
        end
    end

    assign wr_en     = op.do_write || op.do_read;
    assign slot_addr = AW'(qidx_reg) * AW'(QUEUE_DEPTH) + AW'(slot_pos);

endmodule
